[sv/dq_pkg.sv]
`default_nettype none

package dq_pkg;

	typedef enum logic [1:0] {
		REQ_PUSH_BACK  = 2'd0,
		REQ_POP_BACK   = 2'd1,
		REQ_PUSH_FRONT = 2'd2,
		REQ_POP_FRONT  = 2'd3
	} req_t;

	typedef enum logic [1:0] {
		ST_OK    = 2'd0,
		ST_FULL  = 2'd1,
		ST_EMPTY = 2'd2
	} resp_code_t;

	// per-transaction info carried from the control stage to the output register
	typedef struct packed {
		resp_code_t status;
		logic       pop_ok;
	} res_info_t;

endpackage

`default_nettype wire

[sv/dq_ram.sv]
`default_nettype none

module dq_ram #(
	parameter int WIDTH = 32,
	parameter int DEPTH = 1024
) (
	input  wire logic                     clk,
	input  wire logic                     we,
	input  wire logic [$clog2(DEPTH)-1:0] waddr,
	input  wire logic [WIDTH-1:0]         wdata,
	input  wire logic                     re,
	input  wire logic [$clog2(DEPTH)-1:0] raddr,
	output logic      [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem[raddr];
		end
	end

endmodule

`default_nettype wire

[sv/dq_ctrl.sv]
`default_nettype none

module dq_ctrl
	import dq_pkg::*;
#(
	parameter int DEPTH      = 1024,
	parameter int DATA_WIDTH = 32
) (
	input  wire logic                          clk,
	input  wire logic                          arst_n,
	input  wire logic                          in_valid,
	output logic                               in_stall,
	input  wire logic [1:0]                    req_type,
	input  wire logic signed [31:0]            data_in,
	// ram port
	output logic                               ram_we,
	output logic [$clog2(DEPTH)-1:0]           ram_waddr,
	output logic [DATA_WIDTH-1:0]              ram_wdata,
	output logic                               ram_re,
	output logic [$clog2(DEPTH)-1:0]           ram_raddr,
	// to output stage
	output logic                               valid_s1,
	output res_info_t                          info_s1,
	output logic [$clog2(DEPTH+1)-1:0]         occ_s1,
	input  wire logic                          take_s1
);

	localparam int IDX_W = $clog2(DEPTH);
	localparam int CNT_W = $clog2(DEPTH + 1);
	localparam logic [CNT_W:0]   DEPTH_W  = (CNT_W + 1)'(DEPTH);
	localparam logic [CNT_W-1:0] DEPTH_C  = CNT_W'(DEPTH);
	localparam logic [IDX_W-1:0] IDX_LAST = IDX_W'(DEPTH - 1);

	logic [IDX_W-1:0] head_q, head_nxt, head_dec, head_inc;
	logic [CNT_W-1:0] count_q, count_nxt, count_dec;
	logic [CNT_W:0]   back_sum, back_m1_sum;
	logic [IDX_W-1:0] back_slot, back_m1_slot;
	logic             accept, full, empty;
	res_info_t        info_nxt;
	logic [63:0]      din_ext;

	assign in_stall = valid_s1 && !take_s1;
	assign accept   = in_valid && !in_stall;

	assign full      = (count_q == DEPTH_C);
	assign empty     = (count_q == '0);
	assign count_dec = count_q - CNT_W'(1);
	assign head_dec  = (head_q == '0) ? IDX_LAST : head_q - IDX_W'(1);
	assign head_inc  = (head_q == IDX_LAST) ? '0 : head_q + IDX_W'(1);

	// ring position: (head + offset) mod DEPTH, sum stays below 2*DEPTH
	assign back_sum    = (CNT_W + 1)'(head_q) + (CNT_W + 1)'(count_q);
	assign back_m1_sum = (CNT_W + 1)'(head_q) + (CNT_W + 1)'(count_dec);
	assign back_slot    = (back_sum >= DEPTH_W) ? IDX_W'(back_sum - DEPTH_W)
	                                            : IDX_W'(back_sum);
	assign back_m1_slot = (back_m1_sum >= DEPTH_W) ? IDX_W'(back_m1_sum - DEPTH_W)
	                                               : IDX_W'(back_m1_sum);

	assign din_ext   = {32'd0, data_in};
	assign ram_wdata = din_ext[DATA_WIDTH-1:0];

	always_comb begin
		head_nxt        = head_q;
		count_nxt       = count_q;
		ram_we          = 1'b0;
		ram_re          = 1'b0;
		ram_waddr       = back_slot;
		ram_raddr       = back_m1_slot;
		info_nxt.status = ST_OK;
		info_nxt.pop_ok = 1'b0;
		case (req_t'(req_type))
			REQ_PUSH_BACK: begin
				if (full) begin
					info_nxt.status = ST_FULL;
				end else begin
					ram_we    = accept;
					ram_waddr = back_slot;
					count_nxt = count_q + CNT_W'(1);
				end
			end
			REQ_POP_BACK: begin
				if (empty) begin
					info_nxt.status = ST_EMPTY;
				end else begin
					ram_re          = accept;
					ram_raddr       = back_m1_slot;
					count_nxt       = count_dec;
					info_nxt.pop_ok = 1'b1;
				end
			end
			REQ_PUSH_FRONT: begin
				if (full) begin
					info_nxt.status = ST_FULL;
				end else begin
					ram_we    = accept;
					ram_waddr = head_dec;
					head_nxt  = head_dec;
					count_nxt = count_q + CNT_W'(1);
				end
			end
			REQ_POP_FRONT: begin
				if (empty) begin
					info_nxt.status = ST_EMPTY;
				end else begin
					ram_re          = accept;
					ram_raddr       = head_q;
					head_nxt        = head_inc;
					count_nxt       = count_dec;
					info_nxt.pop_ok = 1'b1;
				end
			end
			default: begin
				info_nxt.status = ST_OK;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			head_q   <= '0;
			count_q  <= '0;
			valid_s1 <= 1'b0;
		end else begin
			if (accept) begin
				head_q  <= head_nxt;
				count_q <= count_nxt;
			end
			if (accept) begin
				valid_s1 <= 1'b1;
			end else if (take_s1) begin
				valid_s1 <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			info_s1 <= info_nxt;
			occ_s1  <= count_nxt;
		end
	end

endmodule

`default_nettype wire

[sv/double_ended_queue_unit.sv]
// Double-ended queue of DEPTH words in a single-port-write / single-port-read
// RAM used as a ring with a head pointer and an entry count. Each transaction
// pushes or pops at the back or the front and yields one result with status,
// popped word and occupancy. One transaction is taken per clock while the
// input is not stalled. A result is registered twice, by the RAM's registered
// read and by the output register. A stalled result holds the stage behind
// it, and the input stalls while that stage is full and cannot move. Pointer
// updates happen at acceptance, and a pop always reads the RAM only after the
// push that wrote the entry has written it, so no forwarding path is needed.
// The store powers up undefined; only live entries are ever read, so no
// clearing pass is done after reset.
`default_nettype none

module double_ended_queue_unit
	import dq_pkg::*;
#(
	parameter int DEPTH      = 1024,
	parameter int DATA_WIDTH = 32
) (
	input  wire logic                       clk,
	input  wire logic                       arst_n,
	input  wire logic                       in_valid,
	output logic                            in_stall,
	input  wire logic [1:0]                 req_type,
	input  wire logic signed [31:0]         data_in,
	output logic                            out_valid,
	input  wire logic                       out_stall,
	output logic [1:0]                      status,
	output logic signed [31:0]              data_out,
	output logic [$clog2(DEPTH+1)-1:0]      occupancy
);

	localparam int IDX_W = $clog2(DEPTH);
	localparam int OCC_W = $clog2(DEPTH + 1);

	logic                  ram_we, ram_re;
	logic [IDX_W-1:0]      ram_waddr, ram_raddr;
	logic [DATA_WIDTH-1:0] ram_wdata, ram_rdata;
	logic                  valid_s1, take_s1;
	res_info_t             info_s1;
	logic [OCC_W-1:0]      occ_s1;
	logic [63:0]           rd_ext;
	logic                  out_valid_q;
	logic [1:0]            status_q;
	logic [31:0]           data_q;
	logic [OCC_W-1:0]      occ_q;

	dq_ram #(
		.WIDTH (DATA_WIDTH),
		.DEPTH (DEPTH)
	) u_ram (
		.clk   (clk),
		.we    (ram_we),
		.waddr (ram_waddr),
		.wdata (ram_wdata),
		.re    (ram_re),
		.raddr (ram_raddr),
		.rdata (ram_rdata)
	);

	dq_ctrl #(
		.DEPTH      (DEPTH),
		.DATA_WIDTH (DATA_WIDTH)
	) u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_stall  (in_stall),
		.req_type  (req_type),
		.data_in   (data_in),
		.ram_we    (ram_we),
		.ram_waddr (ram_waddr),
		.ram_wdata (ram_wdata),
		.ram_re    (ram_re),
		.ram_raddr (ram_raddr),
		.valid_s1  (valid_s1),
		.info_s1   (info_s1),
		.occ_s1    (occ_s1),
		.take_s1   (take_s1)
	);

	// read data holds while s1 waits: no new read is issued until s1 moves
	assign take_s1 = valid_s1 && (!out_valid_q || !out_stall);
	assign rd_ext  = 64'(ram_rdata);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (take_s1) begin
			out_valid_q <= 1'b1;
		end else if (!out_stall) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (take_s1) begin
			status_q <= info_s1.status;
			data_q   <= info_s1.pop_ok ? rd_ext[31:0] : 32'd0;
			occ_q    <= occ_s1;
		end
	end

	assign out_valid = out_valid_q;
	assign status    = status_q;
	assign data_out  = data_q;
	assign occupancy = occ_q;

endmodule

`default_nettype wire

[sv/dq_checker.sv]
`default_nettype none

module dq_checker
	import dq_pkg::*;
#(
	parameter int DEPTH = 1024
) (
	input wire logic                       clk,
	input wire logic                       arst_n,
	input wire logic                       out_valid,
	input wire logic                       out_stall,
	input wire logic [1:0]                 status,
	input wire logic signed [31:0]         data_out,
	input wire logic [$clog2(DEPTH+1)-1:0] occupancy
);

	localparam int OCC_W = $clog2(DEPTH + 1);
	localparam logic [OCC_W-1:0] DEPTH_C = OCC_W'(DEPTH);

	// a stalled transaction keeps its payload
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_stall |=> out_valid && $stable(status) && $stable(data_out)
			&& $stable(occupancy))
		else $error("output transaction changed while stalled");

	a_refused_zero: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && status != ST_OK |-> data_out == 32'sd0)
		else $error("refused request returned nonzero data");

	a_full_occ: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && status == ST_FULL |-> occupancy == DEPTH_C)
		else $error("full status with partial occupancy");

	a_empty_occ: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && status == ST_EMPTY |-> occupancy == '0)
		else $error("empty status with nonzero occupancy");

	a_occ_range: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> occupancy <= DEPTH_C)
		else $error("occupancy above depth");

endmodule

bind double_ended_queue_unit dq_checker #(
	.DEPTH (DEPTH)
) u_dq_checker (
	.clk       (clk),
	.arst_n    (arst_n),
	.out_valid (out_valid),
	.out_stall (out_stall),
	.status    (status),
	.data_out  (data_out),
	.occupancy (occupancy)
);

`default_nettype wire

[tb/sv/deq_checker.sv]
`timescale 1ns / 100ps

// Watches both channels of the deque, keeps its own copy of the ring and
// compares every result with the oldest outstanding prediction.
module deq_checker
	import dq_pkg::*;
#(
	parameter int DEPTH = 1024
) (
	input  wire logic                         clk,
	input  wire logic                         arst_n,
	input  wire logic                         in_valid,
	input  wire logic                         in_stall,
	input  wire logic [1:0]                   req_type,
	input  wire logic signed [31:0]           data_in,
	input  wire logic                         out_valid,
	input  wire logic                         out_stall,
	input  wire logic [1:0]                   status,
	input  wire logic signed [31:0]           data_out,
	input  wire logic [$clog2(DEPTH+1)-1:0]   occupancy,
	output int                                mismatches,
	output int                                pending,
	output int                                level,
	output int                                peak_level,
	output int                                full_refusals,
	output int                                empty_refusals,
	output int                                popped
);

	localparam int OCC_W        = $clog2(DEPTH + 1);
	localparam int IDX_W        = $clog2(DEPTH);
	localparam int REPORT_LIMIT = 10;

	typedef struct packed {
		resp_code_t         st;
		logic signed [31:0] word;
		logic [OCC_W-1:0]   fill;
	} deq_result_t;

	logic signed [31:0] words [DEPTH];
	int unsigned        front_idx;
	int unsigned        count;
	deq_result_t        expected_q [$];

	// Applies one request to the shadow ring and returns the result it yields.
	function automatic deq_result_t next_deq_result(req_t op, logic signed [31:0] word);
		deq_result_t r;
		r.st   = ST_OK;
		r.word = '0;
		case (op)
		REQ_PUSH_BACK: begin
			if (count == DEPTH) begin
				r.st = ST_FULL;
			end else begin
				words[IDX_W'((front_idx + count) % DEPTH)] = word;
				count++;
			end
		end
		REQ_POP_BACK: begin
			if (count == 0) begin
				r.st = ST_EMPTY;
			end else begin
				count--;
				r.word = words[IDX_W'((front_idx + count) % DEPTH)];
			end
		end
		REQ_PUSH_FRONT: begin
			if (count == DEPTH) begin
				r.st = ST_FULL;
			end else begin
				front_idx = (front_idx + DEPTH - 1) % DEPTH;
				words[IDX_W'(front_idx)] = word;
				count++;
			end
		end
		default: begin
			if (count == 0) begin
				r.st = ST_EMPTY;
			end else begin
				r.word    = words[IDX_W'(front_idx)];
				front_idx = (front_idx + 1) % DEPTH;
				count--;
			end
		end
		endcase
		r.fill = OCC_W'(count);
		return r;
	endfunction

	always @(posedge clk or negedge arst_n) begin
		deq_result_t exp_res;
		deq_result_t new_res;
		if (!arst_n) begin
			front_idx = 0;
			count     = 0;
			expected_q.delete();
		end else begin
			// results first, so a stray result cannot match a same-cycle request
			if (out_valid && !out_stall) begin
				if (expected_q.size() == 0) begin
					mismatches++;
					if (mismatches <= REPORT_LIMIT)
						$display("%0t: unexpected result: status %0d data %0d occ %0d",
							$time, status, data_out, occupancy);
				end else begin
					exp_res = expected_q[0];
					expected_q.delete(0);
					if (status !== exp_res.st || data_out !== exp_res.word ||
							occupancy !== exp_res.fill) begin
						mismatches++;
						if (mismatches <= REPORT_LIMIT)
							$display({"%0t: expected status %0d data %0d occ %0d, ",
								"got status %0d data %0d occ %0d"},
								$time, exp_res.st, exp_res.word, exp_res.fill,
								status, data_out, occupancy);
					end
				end
			end
			if (in_valid && !in_stall) begin
				new_res = next_deq_result(req_t'(req_type), data_in);
				expected_q = {expected_q, new_res};
				case (new_res.st)
				ST_FULL:  full_refusals++;
				ST_EMPTY: empty_refusals++;
				default: begin
					if (req_type == REQ_POP_BACK || req_type == REQ_POP_FRONT)
						popped++;
				end
				endcase
			end
		end
		level   = count;
		pending = expected_q.size();
		if (level > peak_level)
			peak_level = level;
	end

endmodule

[tb/sv/testbench.sv]
`timescale 1ns / 100ps

module testbench;
	import dq_pkg::*;

	localparam int DEPTH        = 1024;
	localparam int OCC_W        = $clog2(DEPTH + 1);
	localparam int CLK_PERIOD   = 10;
	localparam int RESET_CYCLES = 5;
	localparam int CYCLE_LIMIT  = 300000;
	localparam int TAIL_CYCLES  = 8;

	localparam int MIX_ITEMS    = 150;
	localparam int EDGE_ITEMS   = 40;
	localparam int RANDOM_ITEMS = 1450;

	// idling schedule, by number of accepted transactions
	localparam int PHASE_A_END  = 500;
	localparam int PHASE_B_END  = 1000;

	// long receiver hold-off to back the pipeline up into the input
	localparam int HOLD_AT      = 200;
	localparam int HOLD_CYCLES  = 400;

	logic               clk       = 1'b0;
	logic               arst_n    = 1'b0;
	logic               in_valid  = 1'b0;
	logic [1:0]         req_type  = REQ_PUSH_BACK;
	logic signed [31:0] data_in   = '0;
	logic               out_stall = 1'b0;
	logic               in_stall;
	logic               out_valid;
	logic [1:0]         status;
	logic signed [31:0] data_out;
	logic [OCC_W-1:0]   occupancy;

	int mismatches, pending, fill_level, peak_level;
	int full_refusals, empty_refusals, popped;
	int sent_cnt;
	int rnd_cnt;
	int cycle_cnt;
	int hold_left;
	bit hold_done;

	double_ended_queue_unit #(
		.DEPTH      (DEPTH),
		.DATA_WIDTH (32)
	) dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_stall  (in_stall),
		.req_type  (req_type),
		.data_in   (data_in),
		.out_valid (out_valid),
		.out_stall (out_stall),
		.status    (status),
		.data_out  (data_out),
		.occupancy (occupancy)
	);

	deq_checker #(
		.DEPTH (DEPTH)
	) deq_chk (
		.clk            (clk),
		.arst_n         (arst_n),
		.in_valid       (in_valid),
		.in_stall       (in_stall),
		.req_type       (req_type),
		.data_in        (data_in),
		.out_valid      (out_valid),
		.out_stall      (out_stall),
		.status         (status),
		.data_out       (data_out),
		.occupancy      (occupancy),
		.mismatches     (mismatches),
		.pending        (pending),
		.level          (fill_level),
		.peak_level     (peak_level),
		.full_refusals  (full_refusals),
		.empty_refusals (empty_refusals),
		.popped         (popped)
	);

	always #(CLK_PERIOD / 2) clk = ~clk;

	function automatic int unsigned sender_idle_pct();
		return (sent_cnt < PHASE_A_END) ? 38 : (sent_cnt < PHASE_B_END) ? 55 : 0;
	endfunction

	function automatic int unsigned receiver_idle_pct();
		return (sent_cnt < PHASE_A_END) ? 55 : (sent_cnt < PHASE_B_END) ? 38 : 0;
	endfunction

	function automatic logic signed [31:0] rand_word();
		case ($urandom_range(15))
		0: return 32'sh7FFF_FFFF;
		1: return 32'sh8000_0000;
		2: return '0;
		3: return '1;
		default: return $urandom();
		endcase
	endfunction

	// push_pct biases the walk toward the full or the empty end
	function automatic req_t pick_req(int unsigned push_pct);
		bit at_front;
		at_front = 1'($urandom_range(1));
		if ($urandom_range(99) < push_pct)
			return at_front ? REQ_PUSH_FRONT : REQ_PUSH_BACK;
		return at_front ? REQ_POP_FRONT : REQ_POP_BACK;
	endfunction

	// called at a falling edge; returns at the falling edge after acceptance
	task automatic send_req(input req_t op, input logic signed [31:0] word);
		while ($urandom_range(99) < sender_idle_pct()) begin
			in_valid <= 1'b0;
			@(negedge clk);
		end
		in_valid <= 1'b1;
		req_type <= op;
		data_in  <= word;
		do @(posedge clk); while (in_stall);
		sent_cnt++;
		@(negedge clk);
	endtask

	task automatic send_random(input int unsigned push_pct);
		send_req(pick_req(push_pct), rand_word());
		rnd_cnt++;
	endtask

	always @(negedge clk) begin
		if (!hold_done && sent_cnt >= HOLD_AT) begin
			hold_left = HOLD_CYCLES;
			hold_done = 1'b1;
		end
		if (hold_left != 0) begin
			hold_left--;
			out_stall <= 1'b1;
		end else begin
			out_stall <= ($urandom_range(99) < receiver_idle_pct());
		end
	end

	initial begin
		while (cycle_cnt < CYCLE_LIMIT) begin
			@(posedge clk);
			cycle_cnt++;
		end
		$display("timeout after %0d cycles, %0d results outstanding", cycle_cnt, pending);
		$display("SCOREBOARD MISMATCH");
		$finish;
	end

	initial begin
		repeat (RESET_CYCLES) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		// refused pops on an empty deque
		send_req(REQ_POP_BACK, rand_word());
		send_req(REQ_POP_FRONT, rand_word());
		// extreme words at both ends; first front push wraps the head
		send_req(REQ_PUSH_BACK, 32'sh7FFF_FFFF);
		send_req(REQ_PUSH_FRONT, 32'sh8000_0000);
		send_req(REQ_PUSH_BACK, '1);
		send_req(REQ_PUSH_FRONT, '0);
		send_req(REQ_PUSH_BACK, 32'sh5555_5555);
		send_req(REQ_PUSH_FRONT, 32'shAAAA_AAAA);
		send_req(REQ_POP_FRONT, rand_word());
		send_req(REQ_POP_BACK, rand_word());
		send_req(REQ_POP_FRONT, rand_word());
		send_req(REQ_POP_BACK, rand_word());
		send_req(REQ_POP_FRONT, rand_word());
		send_req(REQ_POP_BACK, rand_word());
		send_req(REQ_POP_FRONT, rand_word());
		// pop right behind the push of the same entry
		send_req(REQ_PUSH_BACK, 32'sh1234_5678);
		send_req(REQ_POP_BACK, rand_word());
		send_req(REQ_PUSH_FRONT, 32'shEDCB_A987);
		send_req(REQ_POP_FRONT, rand_word());
		send_req(REQ_PUSH_BACK, 32'sh0F0F_F0F0);
		send_req(REQ_POP_FRONT, rand_word());

		// random walk near the empty end
		repeat (MIX_ITEMS) send_random(50);
		// fill to capacity, work at the full end
		while (fill_level != DEPTH) send_random(98);
		repeat (EDGE_ITEMS) send_random(80);
		// mostly pops for the rest of the run
		while (rnd_cnt < RANDOM_ITEMS) send_random(10);
		in_valid <= 1'b0;

		while (pending != 0) @(posedge clk);
		repeat (TAIL_CYCLES) @(posedge clk);

		$display("%0d transactions, %0d words popped, peak occupancy %0d of %0d",
			sent_cnt, popped, peak_level, DEPTH);
		$display("%0d pushes refused at full, %0d pops refused on empty, %0d mismatches",
			full_refusals, empty_refusals, mismatches);
		if (mismatches == 0 && pending == 0) begin
			$display("SCOREBOARD CLEAN");
		end else begin
			$display("SCOREBOARD MISMATCH");
		end
		$finish;
	end

endmodule
